/* sv/erqe_pkg.sv */
// Package for the edge ribbon quad expander: widths, reset values, constants.
// No dependencies.
`timescale 1ns / 1ps
package erqe_pkg;
	localparam int NodeDepth = 1024;
	localparam int FracBits  = 16;
	localparam int CoordW    = 32;
	localparam int IndexW    = 10;
	localparam int WidthW    = 31;
	localparam int VnumW     = 16;
	localparam logic [WidthW-1:0] EdgeWidthReset = 31'd131072;
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EDGE = 1'b1;
endpackage

/* sv/erqe_if.sv */
// Valid/ready channel interfaces for request and vertex beats.
// Depends on erqe_pkg.
`timescale 1ns / 1ps
interface erqe_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [erqe_pkg::IndexW-1:0] node_index;
	logic [erqe_pkg::IndexW-1:0] end_index;
	logic signed [erqe_pkg::CoordW-1:0] pos_x;
	logic signed [erqe_pkg::CoordW-1:0] pos_y;
	logic signed [erqe_pkg::CoordW-1:0] pos_z;
	logic restart;
	modport source (output valid, req_type, node_index, end_index, pos_x, pos_y, pos_z,
		restart, input ready);
	modport sink (input valid, req_type, node_index, end_index, pos_x, pos_y, pos_z,
		restart, output ready);
endinterface

interface erqe_vert_if;
	logic valid;
	logic ready;
	logic signed [erqe_pkg::CoordW-1:0] vert_x;
	logic signed [erqe_pkg::CoordW-1:0] vert_y;
	logic signed [erqe_pkg::CoordW-1:0] vert_z;
	logic [erqe_pkg::VnumW-1:0] vertex_number;
	logic [1:0] corner;
	logic last;
	modport source (output valid, vert_x, vert_y, vert_z, vertex_number, corner, last,
		input ready);
	modport sink (input valid, vert_x, vert_y, vert_z, vertex_number, corner, last,
		output ready);
endinterface

/* sv/erqe_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module erqe_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* sv/edge_ribbon_quad_expander.sv */
// Top level of the edge ribbon quad expander: node tables, sequencer, shared
// restoring square-root / divide unit. Depends on erqe_pkg, erqe_if, erqe_ram.
//
//  channel   dir   beat carries
//  req       in    req_type, node_index, end_index, pos_x/y/z, restart
//  vert      out   vert_x/y/z, vertex_number, corner, last
//  cfg       in    cfg_we, cfg_wdata (edge_width)
//
// A load is written at its accept edge, so loads can be accepted every cycle.
// An edge runs the read/setup states (S_RDA to S_SQ), 33 square-root steps,
// 2 x 63 divide steps and 4 vertex beats; a short edge drops after the root.
// The one shared subtract/compare unit serves the root and both divides.
// arst_n resets control state and sets edge_width to EdgeWidthReset. Output
// stalls hold the current vertex; req is not ready until an item is finished.
`timescale 1ns / 1ps
module edge_ribbon_quad_expander #(
	parameter int NODE_DEPTH = erqe_pkg::NodeDepth,
	parameter int FRAC_BITS  = erqe_pkg::FracBits
) (
	input  logic clk,
	input  logic arst_n,
	erqe_req_if.sink    req,
	erqe_vert_if.source vert,
	input  logic cfg_we,
	input  logic [erqe_pkg::WidthW-1:0] cfg_wdata
);
	localparam int AW = $clog2(NODE_DEPTH);
	localparam int EpsRaw = ((1 << FRAC_BITS) + 5000) / 10000;
	localparam int Eps = (EpsRaw == 0) ? 1 : EpsRaw;
	localparam int CW = erqe_pkg::CoordW;
	// remainder width for the root; also covers 63-bit dividend steps
	localparam int RW = 36;

	typedef enum logic [3:0] {
		S_IDLE, S_RDA, S_RDB, S_LATA, S_LATB, S_DIFF, S_SQ, S_SQRT,
		S_DIVX, S_DIVZ, S_EMIT
	} state_t;

	state_t state_q;
	logic [erqe_pkg::WidthW-1:0] ew_q;
	logic [erqe_pkg::VnumW-1:0] vcnt_q;
	logic [AW-1:0] ia_q, ib_q, addr;
	logic we;
	logic [CW-1:0] rx, ry, rz;
	logic signed [CW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic signed [CW:0] dx_q, dz_q;
	logic [CW-1:0] mx_q, mz_q;
	logic [65:0] sq_q;
	logic [RW-1:0] rem_q;
	logic [32:0] root_q;
	logic [62:0] dvd_q;
	logic [62:0] quo_q;
	logic [5:0] step_q;
	logic [CW-1:0] nx_q, nz_q;
	logic [1:0] corner_q;
	logic [63:0] prod;
	logic [RW-1:0] rem_sh, trial, dsh;

	always_comb begin
		we = (state_q == S_IDLE) && req.valid && (req.req_type == erqe_pkg::REQ_LOAD);
		if (state_q == S_IDLE) begin
			addr = AW'(req.node_index % NODE_DEPTH);
		end else if (state_q == S_RDA) begin
			addr = ib_q;
		end else begin
			addr = ia_q;
		end
	end

	erqe_ram #(.Width(CW), .Depth(NODE_DEPTH)) u_ram_x (
		.clk, .we, .addr, .wdata(req.pos_x), .rdata(rx));
	erqe_ram #(.Width(CW), .Depth(NODE_DEPTH)) u_ram_y (
		.clk, .we, .addr, .wdata(req.pos_y), .rdata(ry));
	erqe_ram #(.Width(CW), .Depth(NODE_DEPTH)) u_ram_z (
		.clk, .we, .addr, .wdata(req.pos_z), .rdata(rz));

	// shared unit: restoring step, root trial or divisor compare
	always_comb begin
		prod = (state_q == S_DIVX) ? 64'(mx_q) * 64'(ew_q[30:1])
			: 64'(mz_q) * 64'(ew_q[30:1]);
		if (state_q == S_SQRT) begin
			rem_sh = {rem_q[RW-3:0], sq_q[65:64]};
			trial  = RW'({root_q, 2'b01});
		end else begin
			rem_sh = {rem_q[RW-2:0], dvd_q[62]};
			trial  = RW'(root_q);
		end
		dsh = rem_sh - trial;
	end

	assign req.ready = (state_q == S_IDLE);
	assign vert.valid = (state_q == S_EMIT);

	always_comb begin
		unique case (corner_q)
			2'd0: begin vert.vert_x = ax_q + nx_q; vert.vert_z = az_q + nz_q; vert.vert_y = ay_q; end
			2'd1: begin vert.vert_x = ax_q - nx_q; vert.vert_z = az_q - nz_q; vert.vert_y = ay_q; end
			2'd2: begin vert.vert_x = bx_q - nx_q; vert.vert_z = bz_q - nz_q; vert.vert_y = by_q; end
			default: begin vert.vert_x = bx_q + nx_q; vert.vert_z = bz_q + nz_q; vert.vert_y = by_q; end
		endcase
	end
	assign vert.vertex_number = vcnt_q;
	assign vert.corner = corner_q;
	assign vert.last = (corner_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ew_q     <= erqe_pkg::EdgeWidthReset;
			vcnt_q   <= '0;
			corner_q <= '0;
			step_q   <= '0;
		end else begin
			if (cfg_we) begin
				ew_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (req.restart) begin
							vcnt_q <= '0;
						end
						ia_q <= AW'(req.node_index % NODE_DEPTH);
						ib_q <= AW'(req.end_index % NODE_DEPTH);
						if (req.req_type == erqe_pkg::REQ_EDGE) begin
							state_q <= S_RDA;
						end
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: begin
					bx_q <= rx; by_q <= ry; bz_q <= rz;
					state_q <= S_LATA;
				end
				S_LATA: begin
					ax_q <= rx; ay_q <= ry; az_q <= rz;
					state_q <= S_LATB;
				end
				S_LATB: begin
					dx_q <= {bx_q[CW-1], bx_q} - {ax_q[CW-1], ax_q};
					dz_q <= {bz_q[CW-1], bz_q} - {az_q[CW-1], az_q};
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					mx_q <= dx_q[CW] ? CW'(-dx_q) : dx_q[CW-1:0];
					mz_q <= dz_q[CW] ? CW'(-dz_q) : dz_q[CW-1:0];
					state_q <= S_SQ;
				end
				S_SQ: begin
					// exact sum of squares
					sq_q <= 66'(64'(mx_q) * 64'(mx_q)) + 66'(64'(mz_q) * 64'(mz_q));
					rem_q <= '0;
					root_q <= '0;
					step_q <= 6'd32;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					sq_q <= {sq_q[63:0], 2'b00};
					root_q <= {root_q[31:0], rem_sh >= trial};
					if (step_q == 6'd0) begin
						if (({root_q[31:0], rem_sh >= trial} < 33'(Eps))) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_DIVX;
							rem_q <= '0;
							dvd_q <= prod[62:0];
							quo_q <= '0;
							step_q <= 6'd62;
						end
					end else begin
						rem_q <= (rem_sh >= trial) ? dsh : rem_sh;
						step_q <= step_q - 6'd1;
					end
				end
				S_DIVX, S_DIVZ: begin
					if (step_q == 6'd0) begin
						// quotient never exceeds hw, so it fits 32 bits
						if (state_q == S_DIVX) begin
							nx_q <= dz_q[CW] ? {quo_q[30:0], rem_sh >= trial}
								: CW'(-{quo_q[30:0], rem_sh >= trial});
							rem_q <= '0;
							dvd_q <= prod[62:0];
							quo_q <= '0;
							step_q <= 6'd62;
							state_q <= S_DIVZ;
						end else begin
							nz_q <= dx_q[CW] ? CW'(-{quo_q[30:0], rem_sh >= trial})
								: {quo_q[30:0], rem_sh >= trial};
							corner_q <= '0;
							state_q <= S_EMIT;
						end
					end else begin
						dvd_q <= {dvd_q[61:0], 1'b0};
						rem_q <= (rem_sh >= trial) ? dsh : rem_sh;
						quo_q <= {quo_q[61:0], rem_sh >= trial};
						step_q <= step_q - 6'd1;
					end
				end
				S_EMIT: begin
					if (vert.ready) begin
						vcnt_q <= vcnt_q + 1'b1;
						corner_q <= corner_q + 2'd1;
						if (corner_q == 2'd3) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		vert.valid |-> !req.ready) else $error("ready while emitting");
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(vert.valid && vert.ready && vert.last) |=> req.ready) else $error("no return to idle");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vert.valid && !vert.ready) |=> $stable(vert.vertex_number)) else $error("vertex moved");
`endif
endmodule
